### hdl/ctsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctsr_pkg;

  // Fixed-point layout
  localparam int unsigned FRAC_BITS = 23;
  localparam int unsigned WGT_FRAC  = 24;
  localparam int unsigned DIV_STEPS = 24;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [23:0] ONE_FX     = 24'(64'd1 << FRAC_BITS);
  localparam logic [39:0] WEIGHT_ONE = 40'(64'd1 << WGT_FRAC);
  localparam logic [39:0] ACC_MAX    = {40{1'b1}};
  localparam logic [38:0] ERR_MAX    = {39{1'b1}};
  // Starting remainder for ONE^2 / den, top bits of the dividend
  localparam logic [42:0] POW_R0     = 43'(64'd1 << (2 * FRAC_BITS - DIV_STEPS));

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DAMPING = 3'd0,
    CFG_GAIN    = 3'd1,
    CFG_RATE    = 3'd2,
    CFG_IHW     = 3'd3,
    CFG_CENTER  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0] damping;
    logic [23:0] gain;
    logic [15:0] rate;
    logic [23:0] ihw;
    logic [15:0] center;
  } cfg_t;

  // One word handed from the front end to the back end
  typedef struct packed {
    logic [39:0] avg;
    logic [39:0] wgt;
    logic [23:0] t_old;
    logic [15:0] idx;
    logic        last;
  } entry_t;

endpackage

`default_nettype wire

### hdl/ctsr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ctsr_front import ctsr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [23:0] old_power_i,
  input  wire logic [23:0] old_temperature_i,
  input  wire logic [15:0] point_index_i,
  input  wire logic        last_point_i,
  input  wire logic [23:0] damping_i,
  input  wire logic        full_i,
  output logic             push_o,
  output entry_t           entry_o
);

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_AL   = 6'b000010,
    F_AH   = 6'b000100,
    F_WL   = 6'b001000,
    F_WH   = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_e;

  fstate_e     state_q, state_d;
  logic [39:0] avg_q, avg_d, wgt_q, wgt_d;
  logic [23:0] p_old_q, t_old_q;
  logic [15:0] idx_q;
  logic        last_q;
  logic [43:0] pp_q;
  logic [19:0] mul_b;
  logic [43:0] mul_p;
  logic [63:0] full_p;
  logic [39:0] scaled;
  logic [40:0] avg_sum, wgt_sum;
  logic        accept;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign entry_o    = '{avg: avg_q, wgt: wgt_q, t_old: t_old_q, idx: idx_q, last: last_q};

  // Shared 24x20 multiplier: low half then high half of each accumulator
  always_comb begin
    case (state_q)
      F_AL:    mul_b = avg_q[19:0];
      F_AH:    mul_b = avg_q[39:20];
      F_WL:    mul_b = wgt_q[19:0];
      F_WH:    mul_b = wgt_q[39:20];
      default: mul_b = '0;
    endcase
  end

  assign mul_p   = 44'(damping_i) * 44'(mul_b);
  assign full_p  = {mul_p, 20'd0} + 64'(pp_q);
  assign scaled  = full_p[63:24];
  assign avg_sum = 41'(scaled) + 41'(p_old_q);
  assign wgt_sum = 41'(scaled) + 41'(WEIGHT_ONE);

  // Sequencer and accumulator update
  always_comb begin
    state_d = state_q;
    avg_d   = avg_q;
    wgt_d   = wgt_q;
    case (state_q)
      F_IDLE: if (accept) state_d = F_AL;
      F_AL:   state_d = F_AH;
      F_AH: begin
        avg_d   = avg_sum[40] ? ACC_MAX : avg_sum[39:0];
        state_d = F_WL;
      end
      F_WL:   state_d = F_WH;
      F_WH: begin
        wgt_d   = wgt_sum[40] ? ACC_MAX : wgt_sum[39:0];
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
          if (last_q) begin
            avg_d = '0;
            wgt_d = WEIGHT_ONE;
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      avg_q   <= '0;
      wgt_q   <= WEIGHT_ONE;
    end else begin
      state_q <= state_d;
      avg_q   <= avg_d;
      wgt_q   <= wgt_d;
    end
  end

  // Captured word and partial product
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_old_q <= old_power_i;
      t_old_q <= old_temperature_i;
      idx_q   <= point_index_i;
      last_q  <= last_point_i;
    end
    if (state_q == F_AL || state_q == F_WL) begin
      pp_q <= mul_p;
    end else if (state_q == F_IDLE) begin
      pp_q <= '0;
    end
  end

  // Weight never falls below one
  a_wgt_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wgt_q >= WEIGHT_ONE) else $error("weight accumulator below one");

endmodule

`default_nettype wire

### hdl/ctsr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ctsr_queue import ctsr_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  entry_t      wdata_i,
  input  wire logic   pop_i,
  output entry_t      rdata_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o)) else $error("queue over or underrun");

endmodule

`default_nettype wire

### hdl/ctsr_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: quo = floor(r0 * 2^24 / den), r0 < den, one bit a cycle
module ctsr_div import ctsr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [42:0] r0_i,
  input  wire logic [41:0] den_i,
  output logic             done_o,
  output logic [23:0]      quo_o
);

  localparam logic [4:0] LAST_STEP = 5'(DIV_STEPS - 1);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [42:0] r_q, r2;
  logic [41:0] den_q;
  logic [23:0] q_q;
  logic        ge;

  assign r2     = {r_q[41:0], 1'b0};
  assign ge     = r2 >= {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= r0_i;
      den_q <= den_i;
      q_q   <= '0;
    end else if (busy_q) begin
      r_q <= ge ? r2 - {1'b0, den_q} : r2;
      q_q <= {q_q[22:0], ge};
    end
  end

endmodule

`default_nettype wire

### hdl/ctsr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ctsr_back import ctsr_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   empty_i,
  input  entry_t      entry_i,
  output logic        pop_o,
  input  cfg_t        cfg_i,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output logic [23:0] new_temperature_o,
  output logic [23:0] new_power_o,
  output logic [23:0] delta_squared_o,
  output logic [38:0] error_sum_o,
  output logic        sweep_done_o
);

  localparam int unsigned T2_SHIFT = WGT_FRAC - FRAC_BITS;

  typedef enum logic [9:0] {
    B_IDLE   = 10'b0000000001,
    B_DIVT   = 10'b0000000010,
    B_MUL    = 10'b0000000100,
    B_TNEW   = 10'b0000001000,
    B_TERM   = 10'b0000010000,
    B_OFF    = 10'b0000100000,
    B_SQ     = 10'b0001000000,
    B_PSTART = 10'b0010000000,
    B_DIVP   = 10'b0100000000,
    B_OUT    = 10'b1000000000
  } bstate_e;

  bstate_e     state_q, state_d;
  entry_t      ent_q;
  logic        sat_q, neg_q, huge_q, out_valid_q;
  logic [23:0] target_q, stepm_q, dsq_q, tnew_q, power_q;
  logic [38:0] err_q, esum_q;
  logic [30:0] term1_q;
  logic [39:0] term2_q;
  logic [31:0] omag_q;
  logic [40:0] sq_q;
  logic [23:0] t_out_q, p_out_q, d_out_q;
  logic [38:0] e_out_q;
  logic        s_out_q;

  logic        div_start, div_done;
  logic [42:0] div_r0;
  logic [41:0] div_den;
  logic [23:0] div_quo;
  logic        neg, bneg, dneg, huge, load_out;
  logic [23:0] mag, bmag, t_new;
  logic [15:0] dmag;
  logic [39:0] step_p, t2_p, esum_w;
  logic [47:0] dsq_p, dsq_sh, t1_p;
  logic [24:0] t_sum;
  logic signed [41:0] s1, s2, offs;
  logic [41:0] omag;
  logic [63:0] sq_p;

  // Running error sum, clipped at its top
  function automatic logic [38:0] esum_d_fn(input logic [39:0] s);
    esum_d_fn = (s > 40'(ERR_MAX)) ? ERR_MAX : s[38:0];
  endfunction

  // Divider shared between target temperature and Lorentz power
  assign div_start = (state_q == B_IDLE && !empty_i) || (state_q == B_PSTART);
  always_comb begin
    if (state_q == B_PSTART) begin
      div_r0  = POW_R0;
      div_den = 42'(ONE_FX) + 42'(sq_q);
    end else begin
      div_r0  = (entry_i.avg < entry_i.wgt) ? 43'(entry_i.avg) : '0;
      div_den = 42'(entry_i.wgt);
    end
  end

  ctsr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .r0_i    (div_r0),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign pop_o = (state_q == B_IDLE) && !empty_i;

  // Relaxation step and squared delta
  assign neg    = target_q < ent_q.t_old;
  assign mag    = neg ? ent_q.t_old - target_q : target_q - ent_q.t_old;
  assign step_p = 40'(cfg_i.rate) * 40'(mag);
  assign dsq_p  = 48'(mag) * 48'(mag);
  assign dsq_sh = dsq_p >> FRAC_BITS;

  // Temperature update with saturation
  assign t_sum = neg_q ? ((stepm_q >= ent_q.t_old) ? 25'd0 : 25'(ent_q.t_old - stepm_q))
                       : 25'(ent_q.t_old) + 25'(stepm_q);
  assign t_new = (t_sum > 25'(ONE_FX)) ? ONE_FX : t_sum[23:0];
  assign esum_w = 40'(err_q) + 40'(dsq_q);

  // Frequency offset terms
  assign bneg = cfg_i.gain[23];
  assign bmag = bneg ? (~cfg_i.gain + 24'd1) : cfg_i.gain;
  assign t1_p = 48'(bmag) * 48'(tnew_q);
  assign dneg = ent_q.idx < cfg_i.center;
  assign dmag = dneg ? cfg_i.center - ent_q.idx : ent_q.idx - cfg_i.center;
  assign t2_p = 40'(dmag) * 40'(cfg_i.ihw);

  assign s2   = dneg ? -$signed({2'b00, term2_q}) : $signed({2'b00, term2_q});
  assign s1   = bneg ? -$signed(42'(term1_q)) : $signed(42'(term1_q));
  assign offs = s2 - s1;
  assign omag = offs[41] ? 42'(-offs) : 42'(offs);
  assign huge = |omag[41:32];
  assign sq_p = 64'(omag_q) * 64'(omag_q);

  assign load_out = (state_q == B_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:   if (!empty_i) state_d = B_DIVT;
      B_DIVT:   if (div_done) state_d = B_MUL;
      B_MUL:    state_d = B_TNEW;
      B_TNEW:   state_d = B_TERM;
      B_TERM:   state_d = B_OFF;
      B_OFF:    state_d = B_SQ;
      B_SQ:     state_d = B_PSTART;
      B_PSTART: state_d = B_DIVP;
      B_DIVP:   if (div_done) state_d = B_OUT;
      B_OUT:    if (load_out) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
      if (state_q == B_TNEW) begin
        err_q <= ent_q.last ? '0 : esum_d_fn(esum_w);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          ent_q <= entry_i;
          sat_q <= entry_i.avg >= entry_i.wgt;
        end
      end
      B_DIVT: begin
        if (div_done) target_q <= (sat_q || div_quo > ONE_FX) ? ONE_FX : div_quo;
      end
      B_MUL: begin
        neg_q   <= neg;
        stepm_q <= step_p[39:16];
        dsq_q   <= (dsq_sh > 48'(ONE_FX)) ? ONE_FX : dsq_sh[23:0];
      end
      B_TNEW: begin
        tnew_q <= t_new;
        esum_q <= esum_d_fn(esum_w);
      end
      B_TERM: begin
        term1_q <= t1_p[46:16];
        term2_q <= t2_p >> T2_SHIFT;
      end
      B_OFF: begin
        omag_q <= omag[31:0];
        huge_q <= huge;
      end
      B_SQ:   sq_q <= sq_p[63:FRAC_BITS];
      B_DIVP: if (div_done) power_q <= huge_q ? '0 : div_quo;
      default: ;
    endcase
    if (load_out) begin
      t_out_q <= tnew_q;
      p_out_q <= power_q;
      d_out_q <= dsq_q;
      e_out_q <= esum_q;
      s_out_q <= ent_q.last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign new_temperature_o = t_out_q;
  assign new_power_o       = p_out_q;
  assign delta_squared_o   = d_out_q;
  assign error_sum_o       = e_out_q;
  assign sweep_done_o      = s_out_q;

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == B_DIVT || state_q == B_DIVP))
    else $error("divider finished with nobody waiting");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (new_temperature_o <= ONE_FX && new_power_o <= ONE_FX
                     && delta_squared_o <= ONE_FX))
    else $error("result above one");

endmodule

`default_nettype wire

### hdl/thermal_cavity_relaxation_sweep_unit.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  old_power, old_temperature, point_index, last_point
// out       output     out_valid_o/out_stall_i new_temperature, new_power, delta_squared,
//                                             error_sum, sweep_done
// cfg       input      cfg_we_i               cfg_index_i, cfg_data_i
//
// The front end takes one word at a time, updates the average and weight, and stalls
// its input until that word is pushed. The back end works one word at a time with its
// shared restoring divider (two 24-step passes per word: target temperature and Lorentz power).
// A two-word queue parts the ends; results wait in an output register, so a
// stalled output does not hold the front end until the queue fills.
// Reset clears the running sums to their start values; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module thermal_cavity_relaxation_sweep_unit import ctsr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [23:0] old_power_i,
  input  wire logic [23:0] old_temperature_i,
  input  wire logic [15:0] point_index_i,
  input  wire logic        last_point_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [23:0]      new_temperature_o,
  output logic [23:0]      new_power_o,
  output logic [23:0]      delta_squared_o,
  output logic [38:0]      error_sum_o,
  output logic             sweep_done_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  cfg_t   cfg_q;
  entry_t push_data, pop_data;
  logic   push, pop, full, empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.damping <= 24'd15958982;
      cfg_q.gain    <= 24'd65536;
      cfg_q.rate    <= 16'd655;
      cfg_q.ihw     <= 24'd36873;
      cfg_q.center  <= 16'd13650;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DAMPING: cfg_q.damping <= cfg_data_i;
        CFG_GAIN:    cfg_q.gain    <= cfg_data_i;
        CFG_RATE:    cfg_q.rate    <= cfg_data_i[15:0];
        CFG_IHW:     cfg_q.ihw     <= cfg_data_i;
        CFG_CENTER:  cfg_q.center  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  ctsr_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .old_power_i       (old_power_i),
    .old_temperature_i (old_temperature_i),
    .point_index_i     (point_index_i),
    .last_point_i      (last_point_i),
    .damping_i         (cfg_q.damping),
    .full_i            (full),
    .push_o            (push),
    .entry_o           (push_data)
  );

  ctsr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .pop_i   (pop),
    .rdata_o (pop_data),
    .full_o  (full),
    .empty_o (empty)
  );

  ctsr_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .entry_i           (pop_data),
    .pop_o             (pop),
    .cfg_i             (cfg_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .new_temperature_o (new_temperature_o),
    .new_power_o       (new_power_o),
    .delta_squared_o   (delta_squared_o),
    .error_sum_o       (error_sum_o),
    .sweep_done_o      (sweep_done_o)
  );

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import ctsr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_WORDS = 1000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned SETTLE_CYCLES = 100;
  // Index past the end of the register map, the block must ignore it
  localparam logic [2:0] CFG_NONE = 3'd6;
  localparam logic [63:0] ONE = 64'(ONE_FX);
  localparam logic [63:0] ACC_TOP = 64'(ACC_MAX);
  localparam logic [63:0] ERR_TOP = 64'(ERR_MAX);

  typedef enum logic [1:0] {
    JOB_POINT,
    JOB_CFG,
    JOB_DRAIN
  } job_e;

  typedef struct {
    job_e        job;
    logic [23:0] power;
    logic [23:0] temp;
    logic [15:0] idx;
    logic        last;
    logic [2:0]  reg_idx;
    logic [23:0] reg_data;
  } scan_job_t;

  typedef struct {
    logic [23:0] temp;
    logic [23:0] power;
    logic [23:0] dsq;
    logic [38:0] esum;
    logic        done;
  } point_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [23:0] old_power_i = '0;
  logic [23:0] old_temperature_i = '0;
  logic [15:0] point_index_i = '0;
  logic        last_point_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [23:0] new_temperature_o;
  logic [23:0] new_power_o;
  logic [23:0] delta_squared_o;
  logic [38:0] error_sum_o;
  logic        sweep_done_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  thermal_cavity_relaxation_sweep_unit dut (.*);

  // Mirror of the block's registers and running sums
  logic [23:0]        damping;
  logic signed [23:0] gain;
  logic [15:0]        rate;
  logic [23:0]        ihw;
  logic [15:0]        center;
  logic [63:0]        avg_acc, wgt_acc, err_acc;

  scan_job_t     scan_jobs[$];
  point_result_t predicted_points[$];

  int unsigned cycles = 0, words_in = 0, results_seen = 0, errors = 0;
  int unsigned sweeps_done = 0, settings = 0;
  logic        word_taken = 1'b0;
  logic        calm = 1'b0;
  logic        held_once = 1'b0;
  int unsigned send_gap = 0, quiet = 0, stall_gap = 0, hold_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic point_result_t relax_point(input logic [23:0] p, input logic [23:0] t,
                                                input logic [15:0] idx, input logic last);
    point_result_t r;
    logic [63:0] tgt, mag, stepm, tn, dsq, bmag, term1, dmag, term2, omag, den, pw;
    longint signed off;
    logic neg;
    avg_acc = 64'(p) + ((64'(damping) * avg_acc) >> 24);
    if (avg_acc > ACC_TOP) avg_acc = ACC_TOP;
    wgt_acc = 64'(WEIGHT_ONE) + ((64'(damping) * wgt_acc) >> 24);
    if (wgt_acc > ACC_TOP) wgt_acc = ACC_TOP;
    tgt = 64'((80'(avg_acc) << 24) / 80'(wgt_acc));
    if (tgt > ONE) tgt = ONE;
    // move toward the target by the relax rate
    neg = tgt < 64'(t);
    mag = neg ? 64'(t) - tgt : tgt - 64'(t);
    stepm = (64'(rate) * mag) >> 16;
    if (neg) tn = (stepm >= 64'(t)) ? 64'd0 : 64'(t) - stepm;
    else tn = 64'(t) + stepm;
    if (tn > ONE) tn = ONE;
    dsq = (mag * mag) >> FRAC_BITS;
    if (dsq > ONE) dsq = ONE;
    err_acc = err_acc + dsq;
    if (err_acc > ERR_TOP) err_acc = ERR_TOP;
    // Lorentzian of the detuned offset
    bmag = (gain < 0) ? 64'(-longint'(gain)) : 64'(gain);
    term1 = (bmag * tn) >> 16;
    dmag = (idx < center) ? 64'(center - idx) : 64'(idx - center);
    term2 = (dmag * 64'(ihw)) >> (24 - FRAC_BITS);
    off = ((idx < center) ? -longint'(term2) : longint'(term2))
        - ((gain < 0) ? -longint'(term1) : longint'(term1));
    omag = (off < 0) ? 64'(-off) : 64'(off);
    if (omag >= (64'd1 << 32)) begin
      pw = 0;
    end else begin
      den = ONE + ((omag * omag) >> FRAC_BITS);
      pw = (ONE << FRAC_BITS) / den;
    end
    r.temp = tn[23:0];
    r.power = pw[23:0];
    r.dsq = dsq[23:0];
    r.esum = err_acc[38:0];
    r.done = last;
    if (last) begin
      avg_acc = 0;
      wgt_acc = 64'(WEIGHT_ONE);
      err_acc = 0;
    end
    return r;
  endfunction

  task automatic add_point(input logic [23:0] p, input logic [23:0] t,
                           input logic [15:0] idx, input logic last);
    scan_job_t j;
    j = '{JOB_POINT, p, t, idx, last, CFG_NONE, '0};
    scan_jobs.push_back(j);
  endtask

  task automatic add_drain();
    scan_job_t j;
    j = '{JOB_DRAIN, '0, '0, '0, 1'b0, CFG_NONE, '0};
    scan_jobs.push_back(j);
  endtask

  task automatic add_write(input logic [2:0] idx, input logic [23:0] data);
    scan_job_t j;
    j = '{JOB_CFG, '0, '0, '0, 1'b0, idx, data};
    scan_jobs.push_back(j);
  endtask

  // Registers change only once the block has gone quiet
  task automatic add_setting(input logic [23:0] d, input logic [23:0] g, input logic [15:0] r,
                             input logic [23:0] w, input logic [15:0] c);
    add_drain();
    add_write(CFG_DAMPING, d);
    add_write(CFG_GAIN, g);
    add_write(CFG_RATE, r);
    add_write(CFG_IHW, w);
    add_write(CFG_CENTER, c);
    settings++;
  endtask

  function automatic logic [23:0] pick24(input logic [23:0] lo, input logic [23:0] hi);
    int unsigned k;
    k = $urandom_range(0, 5);
    if (k == 0) return lo;
    if (k == 1) return hi;
    return 24'($urandom);
  endfunction

  // Acceptance, prediction, config mirror, result checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping <= 24'd15958982;
      gain    <= 24'sd65536;
      rate    <= 16'd655;
      ihw     <= 24'd36873;
      center  <= 16'd13650;
      avg_acc <= 0;
      wgt_acc <= 64'(WEIGHT_ONE);
      err_acc <= 0;
      word_taken = 1'b0;
    end else begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("thermal_cavity_relaxation_sweep_unit test failed");
        $finish;
      end else begin
        if (cfg_we_i) begin
          case (cfg_idx_e'(cfg_index_i))
            CFG_DAMPING: damping = cfg_data_i;
            CFG_GAIN:    gain = cfg_data_i;
            CFG_RATE:    rate = cfg_data_i[15:0];
            CFG_IHW:     ihw = cfg_data_i;
            CFG_CENTER:  center = cfg_data_i[15:0];
            default: ;
          endcase
        end
        word_taken = in_valid_i && !in_stall_o;
        if (word_taken) begin
          predicted_points.push_back(relax_point(old_power_i, old_temperature_i,
                                                 point_index_i, last_point_i));
          words_in++;
          if (words_in > RANDOM_WORDS * 9 / 10) calm = 1'b1;
        end
        if (out_valid_o && !out_stall_i) begin
          results_seen++;
          if (predicted_points.size() == 0) begin
            $display("%t: result with nothing expected, temp %h power %h", $time,
                     new_temperature_o, new_power_o);
            errors++;
          end else begin
            point_result_t e;
            e = predicted_points.pop_front();
            if (sweep_done_o) sweeps_done++;
            if (new_temperature_o !== e.temp) begin
              $display("%t: new_temperature expected %h got %h", $time, e.temp,
                       new_temperature_o);
              errors++;
            end
            if (new_power_o !== e.power) begin
              $display("%t: new_power expected %h got %h", $time, e.power, new_power_o);
              errors++;
            end
            if (delta_squared_o !== e.dsq) begin
              $display("%t: delta_squared expected %h got %h", $time, e.dsq,
                       delta_squared_o);
              errors++;
            end
            if (error_sum_o !== e.esum) begin
              $display("%t: error_sum expected %h got %h", $time, e.esum, error_sum_o);
              errors++;
            end
            if (sweep_done_o !== e.done) begin
              $display("%t: sweep_done expected %b got %b", $time, e.done, sweep_done_o);
              errors++;
            end
          end
        end
      end
    end
  end

  // Sender: next word, config writes and drain pauses from the job queue
  always @(negedge clk_i) begin
    logic nv, we;
    scan_job_t j;
    if (rst_ni) begin
      nv = in_valid_i && !word_taken;
      we = 1'b0;
      if (!nv) begin
        if (quiet > 0) begin
          quiet--;
        end else if (send_gap > 0) begin
          send_gap--;
        end else if (scan_jobs.size() > 0) begin
          j = scan_jobs[0];
          case (j.job)
            JOB_POINT: begin
              if (!calm && $urandom_range(0, 6) == 0) begin
                send_gap = $urandom_range(1, 9);
              end else begin
                void'(scan_jobs.pop_front());
                nv = 1'b1;
                old_power_i <= j.power;
                old_temperature_i <= j.temp;
                point_index_i <= j.idx;
                last_point_i <= j.last;
              end
            end
            JOB_DRAIN: begin
              if (predicted_points.size() == 0) begin
                void'(scan_jobs.pop_front());
                quiet = 20;
              end
            end
            JOB_CFG: begin
              void'(scan_jobs.pop_front());
              we = 1'b1;
              cfg_index_i <= j.reg_idx;
              cfg_data_i <= j.reg_data;
            end
            default: ;
          endcase
        end
      end
      in_valid_i <= nv;
      cfg_we_i <= we;
    end
  end

  // Receiver: random stall bursts and one long hold to back the block up
  always @(negedge clk_i) begin
    logic s;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        s = 1'b1;
      end else if (!held_once && results_seen >= 300) begin
        held_once = 1'b1;
        hold_left = LONG_HOLD;
        s = 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        s = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_gap = $urandom_range(0, 8);
        s = 1'b1;
      end else begin
        s = 1'b0;
      end
      out_stall_i <= s;
    end
  end

  initial begin
    int unsigned n, len;
    logic [15:0] base;
    logic [23:0] p, t;
    // directed points under the reset settings
    add_point(24'd0, 24'd0, 16'd0, 1'b0);
    add_point(24'hFFFFFF, ONE_FX, 16'hFFFF, 1'b0);
    add_point(ONE_FX, 24'hFFFFFF, 16'd13650, 1'b0);
    add_point(24'hFFFFFF, 24'd0, 16'd13650, 1'b1);
    add_point(24'd0, 24'hFFFFFF, 16'd100, 1'b1);
    // write to an unmapped index, nothing must change
    add_drain();
    add_write(CFG_NONE, 24'hFFFFFF);
    add_point(24'h123456, 24'h234567, 16'd13700, 1'b1);
    // everything at its top but the center at zero, huge offsets drive the power to zero
    add_setting(24'hFFFFFF, 24'h7FFFFF, 16'hFFFF, 24'hFFFFFF, 16'd0);
    add_point(24'hFFFFFF, 24'd0, 16'hFFFF, 1'b0);
    add_point(24'hFFFFFF, ONE_FX, 16'd0, 1'b0);
    add_point(24'd0, 24'hFFFFFF, 16'd1, 1'b1);
    // everything at its bottom but the center at its top, negative gain
    add_setting(24'd0, 24'h800000, 16'd0, 24'd0, 16'hFFFF);
    add_point(24'hFFFFFF, 24'd0, 16'd0, 1'b0);
    add_point(ONE_FX, ONE_FX, 16'hFFFF, 1'b0);
    add_point(24'd0, 24'hFFFFFF, 16'h8000, 1'b1);
    add_setting(24'd15958982, 24'hF00000, 16'd40000, 24'd500000, 16'd30);
    add_point(ONE_FX, 24'd4000000, 16'd30, 1'b0);
    add_point(24'd0, 24'd1, 16'd31, 1'b1);

    // random sweeps, one register setting per phase
    n = 0;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        add_setting(pick24(24'd0, 24'hFFFFFF), pick24(24'h800000, 24'h7FFFFF),
                    16'(pick24(24'd0, 24'hFFFF)), pick24(24'd0, 24'hFFFFFF),
                    16'(pick24(24'd0, 24'hFFFF)));
      end
      while (n < RANDOM_WORDS * (ph + 1) / 6) begin
        len = $urandom_range(1, 30);
        base = 16'($urandom);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            p = 24'($urandom);
            t = 24'($urandom);
          end else begin
            p = 24'($urandom_range(0, ONE_FX));
            t = 24'($urandom_range(0, ONE_FX));
          end
          add_point(p, t, base + 16'(k), (k == len - 1) || ($urandom_range(0, 40) == 0));
          n++;
        end
      end
      // sender holds back until every result is home
      if (ph == 2) add_drain();
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (scan_jobs.size() == 0 && predicted_points.size() == 0 && !in_valid_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d words, %0d sweeps closed, %0d register settings", words_in,
             sweeps_done, settings);
    $display("long output hold taken: %0b, %0d cycles in all", held_once, cycles);
    if (errors == 0 && predicted_points.size() == 0) begin
      $display("thermal_cavity_relaxation_sweep_unit test passed");
    end else begin
      $display("thermal_cavity_relaxation_sweep_unit test failed");
    end
    $finish;
  end

endmodule
